// ===== rtl/core/process_id_probe_table_macros.svh =====
// Assertion macros for the process id probe table checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef PROCESS_ID_PROBE_TABLE_MACROS_SVH
`define PROCESS_ID_PROBE_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIDPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIDPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pidpt_pkg.sv =====
// Shared types, command and outcome codes, and default sizes for the
// process id probe table. Depends on nothing.
package pidpt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;
   localparam int DEFAULT_KEY_BITS    = 22;
   localparam int STATUS_BITS         = 8;
   localparam int CMD_BITS            = 2;
   localparam int OUTCOME_BITS        = 2;

   typedef logic [CMD_BITS-1:0]     cmd_type;
   typedef logic [OUTCOME_BITS-1:0] outcome_type;
   typedef logic [STATUS_BITS-1:0]  status_type;

   // Command codes.
   localparam cmd_type CMD_WATCH = 2'd0;
   localparam cmd_type CMD_CHECK = 2'd1;
   localparam cmd_type CMD_REAP  = 2'd2;

   // Outcome codes.
   localparam outcome_type OUT_OK     = 2'd0;
   localparam outcome_type OUT_FULL   = 2'd1;
   localparam outcome_type OUT_ABSENT = 2'd2;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HOME,
      ST_PROBE,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/pidpt_home.sv =====
// Home slot unit: computes a key modulo the table depth.
// Power-of-two depths take the low bits; other depths use a reciprocal multiplication.
// Depends on pidpt_pkg for the default sizes.
module pidpt_home #(
   parameter int TABLE_DEPTH = pidpt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int KEY_BITS    = pidpt_pkg::DEFAULT_KEY_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [KEY_BITS-1:0]            key,
   output logic                           done,
   output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

   localparam int IDX_BITS = $clog2(TABLE_DEPTH);
   localparam bit IS_POW2  = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

   generate
      if (IS_POW2) begin : g_mask
         localparam int EXT_BITS = (KEY_BITS > IDX_BITS) ? KEY_BITS : IDX_BITS;

         logic [EXT_BITS-1:0] key_ext;
         logic [IDX_BITS-1:0] slot_ff;
         logic                done_ff;

         assign key_ext = EXT_BITS'(key);

         // The home slot is just the low bits of the key.
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               slot_ff <= key_ext[IDX_BITS-1:0];
            end
         end

         assign done = done_ff;
         assign slot = slot_ff;
      end else begin : g_recip
         // For keys below 2**KEY_BITS, the product with the rounded-up reciprocal,
         // shifted right by KEY_BITS + IDX_BITS, is exactly the quotient.
         localparam int SHIFT      = KEY_BITS + IDX_BITS;
         localparam int RECIP_BITS = KEY_BITS + 1;
         localparam int PROD_BITS  = KEY_BITS + RECIP_BITS;
         localparam logic [64:0] RECIP_WIDE =
            ((65'(1) << SHIFT) + 65'(TABLE_DEPTH) - 65'(1)) / 65'(TABLE_DEPTH);
         localparam logic [RECIP_BITS-1:0] RECIP    = RECIP_BITS'(RECIP_WIDE);
         localparam logic [IDX_BITS-1:0]   DEPTH_LO = IDX_BITS'(TABLE_DEPTH);

         logic [KEY_BITS-1:0]  key_ff;
         logic [PROD_BITS-1:0] prod_ff;
         logic                 mul_ff;
         logic [IDX_BITS-1:0]  quo_lo;
         logic [IDX_BITS-1:0]  rem;
         logic [IDX_BITS-1:0]  slot_ff;
         logic                 done_ff;

         // The remainder is below the depth, so only the low bits matter.
         assign quo_lo = IDX_BITS'(prod_ff >> SHIFT);
         assign rem    = IDX_BITS'(key_ff) - quo_lo * DEPTH_LO;

         // Multiply into prod_ff, then subtract into slot_ff.
         always_ff @(posedge clock) begin
            if (reset) begin
               mul_ff  <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               mul_ff  <= start;
               done_ff <= mul_ff;
            end
            if (start) begin
               key_ff  <= key;
               prod_ff <= PROD_BITS'(key) * PROD_BITS'(RECIP);
            end
            if (mul_ff) begin
               slot_ff <= rem;
            end
         end

         assign done = done_ff;
         assign slot = slot_ff;
      end
   endgenerate

endmodule

// ===== rtl/core/process_id_probe_table.sv =====
// Process id probe table: an open-addressed table of process ids.
// Request words carry a command (watch, check or reap), a process id and an
// exit status; each request yields exactly one response word with the outcome,
// the dead flag and stored status of the found entry, and the used and alive
// counts after the command. Both channels use valid/ready.
// The table lives in one synchronous memory of TABLE_DEPTH entries with a
// registered read port; a valid bit per entry makes the table read as empty
// right after reset, so reset needs no clearing pass.
// Only one request is in flight: req_ready is high while the sequencer idles.
// For a power-of-two depth the home slot is the low bits of the id; for other
// depths it comes from a reciprocal multiplication. Probing reads one slot per
// cycle through the memory's read port. A zero id or an unused command skips
// the probe and answers with the absent outcome.
// A finished response sits in an output register; the next request is taken
// while it waits, and that request holds its own response until rsp_ready.
// Depends on pidpt_pkg and pidpt_home.
module process_id_probe_table #(
   parameter int TABLE_DEPTH = pidpt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int KEY_BITS    = pidpt_pkg::DEFAULT_KEY_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pidpt_pkg::cmd_type                req_cmd,
   input  logic [KEY_BITS-1:0]               req_pid,
   input  pidpt_pkg::status_type             req_exit_status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pidpt_pkg::outcome_type            rsp_outcome,
   output logic                              rsp_dead,
   output pidpt_pkg::status_type             rsp_stored_status,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]  rsp_used_count,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]  rsp_alive_count
);

   import pidpt_pkg::*;

   localparam int IDX_BITS   = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_DEPTH - 1);

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic                dead;
      status_type          status;
   } entry_type;

   state_type state_ff, state_in;

   // Request fields held for the command in flight.
   cmd_type             cmd_ff;
   logic [KEY_BITS-1:0] pid_ff;
   status_type          st_ff;

   // Probe position and number of slots already passed.
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [IDX_BITS-1:0] n_ff, n_in;

   // Counts and the pending result.
   logic [COUNT_BITS-1:0] occupied_ff, occupied_in;
   logic [COUNT_BITS-1:0] living_ff, living_in;
   outcome_type           res_outcome_ff, res_outcome_in;
   logic                  res_dead_ff, res_dead_in;
   status_type            res_status_ff, res_status_in;

   // Output register.
   logic                  rsp_valid_ff;
   outcome_type           rsp_outcome_ff;
   logic                  rsp_dead_ff;
   status_type            rsp_status_ff;
   logic [COUNT_BITS-1:0] rsp_used_ff;
   logic [COUNT_BITS-1:0] rsp_alive_ff;

   // Memory and its ports.
   entry_type             mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   entry_type             rd_raw_ff;
   logic                  rd_valid_ff;
   entry_type             rd_entry;
   logic                  mem_rd_en;
   logic [IDX_BITS-1:0]   mem_rd_addr;
   logic                  mem_we;
   entry_type             mem_wr_data;

   // Home slot unit.
   logic                  home_start;
   logic                  home_done;
   logic [IDX_BITS-1:0]   home_slot;

   // Decode and probe decisions.
   logic                  req_take;
   logic                  req_legal;
   logic                  slot_hit;
   logic                  slot_empty;
   logic                  last_probe;
   logic                  probe_end;
   logic [IDX_BITS-1:0]   idx_next;
   logic                  res_load;
   logic                  rsp_load;

   pidpt_home #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_BITS   (KEY_BITS)
   ) u_home (
      .clock(clock),
      .reset(reset),
      .start(home_start),
      .key  (req_pid),
      .done (home_done),
      .slot (home_slot)
   );

   // Request decode and probe evaluation of the slot just read.
   assign req_take  = req_valid && req_ready;
   assign req_legal = (req_pid != '0) &&
                      (req_cmd == CMD_WATCH || req_cmd == CMD_CHECK || req_cmd == CMD_REAP);
   assign rd_entry   = rd_valid_ff ? rd_raw_ff : '0;
   assign slot_hit   = (rd_entry.key == pid_ff);
   assign slot_empty = (rd_entry.key == '0);
   assign last_probe = (n_ff == LAST_IDX);
   assign probe_end  = slot_hit || slot_empty || last_probe;
   assign idx_next   = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_BITS'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = req_legal ? ST_HOME : ST_DONE;
            end
         end
         ST_HOME: begin
            if (home_done) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (probe_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_ready   = 1'b0;
      home_start  = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_next;
      res_load    = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            home_start = req_valid && req_legal;
            res_load   = req_valid && !req_legal;
         end
         ST_HOME: begin
            mem_rd_en   = home_done;
            mem_rd_addr = home_slot;
         end
         ST_PROBE: begin
            mem_rd_en = !probe_end;
            res_load  = probe_end;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Write-back data, result fields and count updates.
   always_comb begin
      mem_we         = 1'b0;
      mem_wr_data    = '{key: pid_ff, dead: 1'b0, status: '0};
      occupied_in    = occupied_ff;
      living_in      = living_ff;
      res_outcome_in = OUT_ABSENT;
      res_dead_in    = 1'b0;
      res_status_in  = '0;
      if (state_ff == ST_PROBE && probe_end) begin
         unique case (cmd_ff)
            CMD_WATCH: begin
               if (slot_hit) begin
                  // Re-arm a known id; the status is kept.
                  mem_we         = 1'b1;
                  mem_wr_data    = '{key: pid_ff, dead: 1'b0, status: rd_entry.status};
                  res_outcome_in = OUT_OK;
                  res_status_in  = rd_entry.status;
                  if (rd_entry.dead) begin
                     living_in = living_ff + COUNT_BITS'(1);
                  end
               end else if (slot_empty) begin
                  mem_we         = 1'b1;
                  res_outcome_in = OUT_OK;
                  occupied_in    = occupied_ff + COUNT_BITS'(1);
                  living_in      = living_ff + COUNT_BITS'(1);
               end else begin
                  res_outcome_in = OUT_FULL;
               end
            end
            CMD_CHECK: begin
               if (slot_hit) begin
                  res_outcome_in = OUT_OK;
                  res_dead_in    = rd_entry.dead;
                  res_status_in  = rd_entry.status;
               end
            end
            CMD_REAP: begin
               if (slot_hit) begin
                  mem_we         = 1'b1;
                  mem_wr_data    = '{key: pid_ff, dead: 1'b1, status: st_ff};
                  res_outcome_in = OUT_OK;
                  res_dead_in    = 1'b1;
                  res_status_in  = st_ff;
                  // A second reap of a dead entry only updates the status.
                  if (!rd_entry.dead && living_ff != '0) begin
                     living_in = living_ff - COUNT_BITS'(1);
                  end
               end
            end
            default: begin
               res_outcome_in = OUT_ABSENT;
            end
         endcase
      end
   end

   // Probe position.
   always_comb begin
      idx_in = idx_ff;
      n_in   = n_ff;
      if (state_ff == ST_HOME && home_done) begin
         idx_in = home_slot;
         n_in   = '0;
      end else if (state_ff == ST_PROBE && !probe_end) begin
         idx_in = idx_next;
         n_in   = n_ff + IDX_BITS'(1);
      end
   end

   // Table memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_raw_ff <= mem[mem_rd_addr];
      end
   end

   // Entry valid bits; an entry that was never written reads as empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (mem_rd_en) begin
            rd_valid_ff <= valid_ff[mem_rd_addr];
         end
      end
   end

   // Control state and counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occupied_ff  <= '0;
         living_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         occupied_ff <= occupied_in;
         living_ff   <= living_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= req_cmd;
         pid_ff <= req_pid;
         st_ff  <= req_exit_status;
      end
      idx_ff <= idx_in;
      n_ff   <= n_in;
      if (res_load) begin
         res_outcome_ff <= res_outcome_in;
         res_dead_ff    <= res_dead_in;
         res_status_ff  <= res_status_in;
      end
      if (rsp_load) begin
         rsp_outcome_ff <= res_outcome_ff;
         rsp_dead_ff    <= res_dead_ff;
         rsp_status_ff  <= res_status_ff;
         rsp_used_ff    <= occupied_ff;
         rsp_alive_ff   <= living_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = rsp_outcome_ff;
   assign rsp_dead          = rsp_dead_ff;
   assign rsp_stored_status = rsp_status_ff;
   assign rsp_used_count    = rsp_used_ff;
   assign rsp_alive_count   = rsp_alive_ff;

endmodule

// ===== rtl/core/pidpt_checker.sv =====
// Port-level assertions for the process id probe table, bound to the top level.
// Depends on pidpt_pkg and process_id_probe_table_macros.svh.
`include "process_id_probe_table_macros.svh"

module pidpt_checker #(
   parameter int TABLE_DEPTH = pidpt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int KEY_BITS    = pidpt_pkg::DEFAULT_KEY_BITS
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input pidpt_pkg::cmd_type                req_cmd,
   input logic [KEY_BITS-1:0]               req_pid,
   input pidpt_pkg::status_type             req_exit_status,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input pidpt_pkg::outcome_type            rsp_outcome,
   input logic                              rsp_dead,
   input pidpt_pkg::status_type             rsp_stored_status,
   input logic [$clog2(TABLE_DEPTH+1)-1:0]  rsp_used_count,
   input logic [$clog2(TABLE_DEPTH+1)-1:0]  rsp_alive_count
);

   import pidpt_pkg::*;

   localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);

   logic req_take;
   logic req_seen;

   assign req_take = req_valid && req_ready;
   // Request payload is watched only for being well formed at acceptance.
   assign req_seen = req_take && (req_cmd == req_cmd) && (req_pid == req_pid) &&
                     (req_exit_status == req_exit_status);

   // One command in flight: acceptance closes the request side in the cycle after.
   `PIDPT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_seen, !req_ready,
      "request accepted while a command is still in flight")

   // A stalled response word holds.
   `PIDPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_outcome) && $stable(rsp_used_count),
      "stalled response changed")

   // Alive entries are a subset of used slots.
   `PIDPT_ASSERT_NOW(a_alive_le_used, clock, reset, rsp_valid,
      rsp_alive_count <= rsp_used_count,
      "alive count exceeds used count")

   // A full table answer needs every slot used.
   `PIDPT_ASSERT_NOW(a_full_used, clock, reset, rsp_valid && rsp_outcome == OUT_FULL,
      rsp_used_count == COUNT_BITS'(TABLE_DEPTH),
      "table full reported with free slots")

   // Only a found entry reports a dead flag or status.
   `PIDPT_ASSERT_NOW(a_miss_clean, clock, reset, rsp_valid && rsp_outcome != OUT_OK,
      !rsp_dead && rsp_stored_status == '0,
      "entry fields reported without a found entry")

endmodule

bind process_id_probe_table pidpt_checker #(
   .TABLE_DEPTH(TABLE_DEPTH),
   .KEY_BITS   (KEY_BITS)
) u_pidpt_checker (.*);
